[rtl/assert_macros.svh]
// Assertion macros shared by the page chain link table RTL.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// The expression holds at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, ck, rn, expr) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (expr)) \
    else $error("assertion failed");
// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");
// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, ck, rn, expr)
`define ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

[rtl/pclt_pkg.sv]
// Types and constants of the page chain link table.
// No dependencies; the top, pclt_dp and pclt_ctrl use it.
`default_nettype none
package pclt_pkg;

  // Request codes carried in req_type.
  typedef enum logic [2:0] {
    OP_ALLOC  = 3'd0,
    OP_SET    = 3'd1,
    OP_FOLLOW = 3'd2,
    OP_FREE   = 3'd3,
    OP_COUNT  = 3'd4
  } req_op_t;

  // Result status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;
  localparam logic [1:0] STAT_SHORT = 2'd3;

  // First data page number and the idle link value.
  localparam int unsigned FIRST_PAGE = 21;
  localparam logic [9:0]  LINK_IDLE  = 10'd0;
  // Largest value a 10-bit result field can show.
  localparam int unsigned MAX10 = 1023;

  typedef struct packed {
    logic [2:0] req_type;
    logic [9:0] page;
    logic [9:0] link_value;
    logic [8:0] hop_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] page_out;
    logic [9:0] idle_count;
  } out_item_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_WALK_RD,
    S_WALK_EV,
    S_FINISH
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic decode;
    logic clear_step;
    logic scan_step;
    logic walk_issue;
    logic walk_eval;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] op;
    logic       page_ok;
    logic       hops_zero;
    logic       clear_last;
    logic       scan_done;
    logic       walk_stop;
    logic       out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

[rtl/page_chain_link_table.sv]
// Page chain link table. After reset a clearing pass writes every entry idle
// while no item is taken. Allocate and count idle scan the whole table, one read a
// cycle; follow and free chain read and evaluate one entry per hop. A new item is
// taken only after the result of the last one is loaded into the output register,
// so items do not overlap; a stalled result held in the output register delays that load.
`default_nettype none
module page_chain_link_table #(
  parameter int NUM_PAGES = 512
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire pclt_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output pclt_pkg::out_item_t      out_item
);

  pclt_pkg::ctrl_cmd_t cmd;
  pclt_pkg::dp_sts_t   sts;

  // Sequencing of each request.
  pclt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Link table and result datapath.
  pclt_dp #(
    .NUM_PAGES (NUM_PAGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

[rtl/pclt_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module pclt_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/pclt_dp.sv]
// Datapath of the page chain link table: link RAM, scan and walk registers,
// result register. Depends on pclt_pkg, pclt_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module pclt_dp #(
  parameter int NUM_PAGES = 512
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pclt_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output pclt_pkg::out_item_t      out_item,
  input  wire pclt_pkg::ctrl_cmd_t cmd,
  output pclt_pkg::dp_sts_t        sts
);

  localparam int IDX_W = $clog2(NUM_PAGES);
  localparam int CNT_W = $clog2(NUM_PAGES + 1);
  localparam int unsigned AREA_END = pclt_pkg::FIRST_PAGE + NUM_PAGES;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PAGES - 1);

  // True when a page number lies in the data area.
  function automatic logic in_area(input logic [9:0] p);
    return (32'(p) >= pclt_pkg::FIRST_PAGE) && (32'(p) < AREA_END);
  endfunction

  // Table index of a data page.
  function automatic logic [IDX_W-1:0] page_idx(input logic [9:0] p);
    return IDX_W'(32'(p) - pclt_pkg::FIRST_PAGE);
  endfunction

  pclt_pkg::in_item_t  req_r, req_nxt;
  pclt_pkg::out_item_t out_item_r, out_item_nxt;
  logic [9:0]       cur_r, cur_nxt;
  logic [8:0]       hop_r, hop_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             iss_done_r, iss_done_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             found_r, found_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [9:0]       pout_r, pout_nxt;
  logic [CNT_W-1:0] idle_r, idle_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [9:0]       ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [9:0]       ram_rdata;

  logic             link_low;
  logic             link_ok;
  logic             is_follow;
  logic [9:0]       idle_sat;

  pclt_ram #(
    .WIDTH (10),
    .DEPTH (NUM_PAGES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Classification of the link just read.
  assign link_low  = 32'(ram_rdata) < pclt_pkg::FIRST_PAGE;
  assign link_ok   = in_area(ram_rdata);
  assign is_follow = req_r.req_type == pclt_pkg::OP_FOLLOW;
  assign idle_sat  = (32'(idle_r) > pclt_pkg::MAX10) ? 10'(pclt_pkg::MAX10) : 10'(idle_r);

  // Next-state logic for all datapath registers and the RAM ports.
  always_comb begin
    req_nxt       = req_r;
    cur_nxt       = cur_r;
    hop_nxt       = hop_r;
    idx_nxt       = idx_r;
    rd_idx_nxt    = rd_idx_r;
    iss_done_nxt  = iss_done_r;
    rd_vld_nxt    = 1'b0;
    found_nxt     = found_r;
    status_nxt    = status_r;
    pout_nxt      = pout_r;
    idle_nxt      = idle_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = pclt_pkg::LINK_IDLE;
    ram_raddr     = page_idx(cur_r);

    // Clearing pass after reset, one entry per cycle.
    if (cmd.clear_step) begin
      ram_we  = 1'b1;
      idx_nxt = (idx_r == LAST_IDX) ? '0 : idx_r + IDX_W'(1);
    end

    // Take a new item and prepare the result registers.
    if (cmd.load) begin
      req_nxt      = in_item;
      cur_nxt      = in_item.page;
      hop_nxt      = in_item.hop_count;
      idx_nxt      = '0;
      iss_done_nxt = 1'b0;
      found_nxt    = 1'b0;
      status_nxt   = (in_item.req_type == pclt_pkg::OP_ALLOC) ?
                     pclt_pkg::STAT_FULL : pclt_pkg::STAT_OK;
      pout_nxt     = '0;
      idle_nxt     = '0;
    end

    // Range check, set link write and follow start.
    if (cmd.decode) begin
      case (req_r.req_type)
        pclt_pkg::OP_SET: begin
          if (in_area(req_r.page)) begin
            ram_we    = 1'b1;
            ram_waddr = page_idx(req_r.page);
            ram_wdata = req_r.link_value;
          end else begin
            status_nxt = pclt_pkg::STAT_RANGE;
          end
        end
        pclt_pkg::OP_FOLLOW: begin
          if (in_area(req_r.page)) begin
            pout_nxt = req_r.page;
          end else begin
            status_nxt = pclt_pkg::STAT_RANGE;
          end
        end
        pclt_pkg::OP_FREE: begin
          if (!in_area(req_r.page)) begin
            status_nxt = pclt_pkg::STAT_RANGE;
          end
        end
        default: begin
        end
      endcase
    end

    // Table scan: one read issued per cycle, its data checked in the next cycle.
    if (cmd.scan_step) begin
      ram_raddr  = idx_r;
      rd_vld_nxt = !iss_done_r;
      rd_idx_nxt = idx_r;
      if (!iss_done_r) begin
        if (idx_r == LAST_IDX) begin
          iss_done_nxt = 1'b1;
          idx_nxt      = '0;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      if (rd_vld_r && (ram_rdata == pclt_pkg::LINK_IDLE)) begin
        if ((req_r.req_type == pclt_pkg::OP_ALLOC) && !found_r) begin
          found_nxt  = 1'b1;
          status_nxt = pclt_pkg::STAT_OK;
          pout_nxt   = 10'(32'(rd_idx_r) + pclt_pkg::FIRST_PAGE);
        end
        if (req_r.req_type == pclt_pkg::OP_COUNT) begin
          idle_nxt = idle_r + CNT_W'(1);
        end
      end
    end

    // One hop of a follow or free walk on the link just read.
    if (cmd.walk_eval) begin
      if (req_r.req_type == pclt_pkg::OP_FREE) begin
        ram_we    = 1'b1;
        ram_waddr = page_idx(cur_r);
      end
      if (link_low) begin
        if (is_follow) begin
          status_nxt = pclt_pkg::STAT_SHORT;
        end
      end else if (!link_ok) begin
        status_nxt = pclt_pkg::STAT_RANGE;
      end else begin
        cur_nxt = ram_rdata;
        if (is_follow) begin
          pout_nxt = ram_rdata;
          hop_nxt  = hop_r - 9'd1;
        end
      end
    end

    // Result register: freed when taken, loaded when the item is done.
    if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.finish) begin
      out_valid_nxt         = 1'b1;
      out_item_nxt.status     = status_r;
      out_item_nxt.page_out   = pout_r;
      out_item_nxt.idle_count = idle_sat;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      iss_done_r  <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      iss_done_r  <= iss_done_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    cur_r      <= cur_nxt;
    hop_r      <= hop_nxt;
    rd_idx_r   <= rd_idx_nxt;
    found_r    <= found_nxt;
    status_r   <= status_nxt;
    pout_r     <= pout_nxt;
    idle_r     <= idle_nxt;
    out_item_r <= out_item_nxt;
  end

  // Status toward the controller.
  always_comb begin
    sts.op         = req_r.req_type;
    sts.page_ok    = in_area(req_r.page);
    sts.hops_zero  = req_r.hop_count == 9'd0;
    sts.clear_last = idx_r == LAST_IDX;
    sts.scan_done  = iss_done_r && !rd_vld_r;
    sts.walk_stop  = link_low || !link_ok || (is_follow && (hop_r == 9'd1));
    sts.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A result is never written over one that is still waiting.
  `ASSERT_IMPL(a_finish_room, clk, rst_n, cmd.finish, !(out_valid_r && out_stall))
  // A walk step always checks the link read in the cycle before.
  `ASSERT_IMPL(a_eval_after_issue, clk, rst_n, cmd.walk_eval, $past(cmd.walk_issue))
  // A table scan never writes the table.
  `ASSERT_IMPL(a_scan_no_write, clk, rst_n, cmd.scan_step, !ram_we)

endmodule
`default_nettype wire

[rtl/pclt_ctrl.sv]
// Controller of the page chain link table: clearing pass and request sequencing.
// Depends on pclt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module pclt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pclt_pkg::dp_sts_t sts,
  output pclt_pkg::ctrl_cmd_t    cmd
);

  pclt_pkg::ctrl_state_t state_r, state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pclt_pkg::S_CLEAR: begin
        if (sts.clear_last) begin
          state_nxt = pclt_pkg::S_IDLE;
        end
      end
      pclt_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = pclt_pkg::S_DECODE;
        end
      end
      pclt_pkg::S_DECODE: begin
        case (pclt_pkg::req_op_t'(sts.op))
          pclt_pkg::OP_ALLOC, pclt_pkg::OP_COUNT: begin
            state_nxt = pclt_pkg::S_SCAN;
          end
          pclt_pkg::OP_FOLLOW: begin
            state_nxt = (sts.page_ok && !sts.hops_zero) ?
                        pclt_pkg::S_WALK_RD : pclt_pkg::S_FINISH;
          end
          pclt_pkg::OP_FREE: begin
            state_nxt = sts.page_ok ? pclt_pkg::S_WALK_RD : pclt_pkg::S_FINISH;
          end
          default: begin
            state_nxt = pclt_pkg::S_FINISH;
          end
        endcase
      end
      pclt_pkg::S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = pclt_pkg::S_FINISH;
        end
      end
      pclt_pkg::S_WALK_RD: begin
        state_nxt = pclt_pkg::S_WALK_EV;
      end
      pclt_pkg::S_WALK_EV: begin
        state_nxt = sts.walk_stop ? pclt_pkg::S_FINISH : pclt_pkg::S_WALK_RD;
      end
      pclt_pkg::S_FINISH: begin
        if (sts.out_free) begin
          state_nxt = pclt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pclt_pkg::S_CLEAR;
      end
    endcase
  end

  // Commands and the input handshake.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      pclt_pkg::S_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      pclt_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      pclt_pkg::S_DECODE: begin
        cmd.decode = 1'b1;
      end
      pclt_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      pclt_pkg::S_WALK_RD: begin
        cmd.walk_issue = 1'b1;
      end
      pclt_pkg::S_WALK_EV: begin
        cmd.walk_eval = 1'b1;
      end
      pclt_pkg::S_FINISH: begin
        cmd.finish = sts.out_free;
      end
      default: begin
      end
    endcase
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pclt_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The clearing pass ends only after its last entry.
  `ASSERT_IMPL(a_clear_done, clk, rst_n,
    (state_r == pclt_pkg::S_IDLE) && ($past(state_r) == pclt_pkg::S_CLEAR),
    $past(sts.clear_last))
  // A finished item leaves only by handing over its result.
  `ASSERT_IMPL(a_finish_handoff, clk, rst_n,
    (state_r == pclt_pkg::S_IDLE) && ($past(state_r) == pclt_pkg::S_FINISH),
    $past(cmd.finish))
  // Every walk check follows a walk read.
  `ASSERT_IMPL(a_walk_order, clk, rst_n,
    state_r == pclt_pkg::S_WALK_EV, $past(state_r) == pclt_pkg::S_WALK_RD)

endmodule
`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the page chain link table.
// Needs pclt_pkg and page_chain_link_table; results are checked against a
// predictor of the table that runs inside this file.
`timescale 1ns / 1ps
module tb_top;
  import pclt_pkg::*;

  localparam int NUM_PAGES = 512;
  localparam int unsigned LAST_PAGE = FIRST_PAGE + NUM_PAGES - 1;
  localparam logic [9:0] LINK_TAIL = 10'd1;
  localparam logic [9:0] LINK_BROKEN = 10'd15;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int RANDOM_ITEMS = 650;
  localparam int DRAIN_CYCLES = 2 * NUM_PAGES + 16;
  localparam int CYCLE_LIMIT = 10000000;

  // Clock and stimulus-side signals.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  in_item_t in_item = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  out_item_t out_item;

  // Expected result typed into a directed row, sent alongside the item.
  logic drv_typed = 1'b0;
  out_item_t drv_want = '0;

  // Predicted link table and the queue of results still to come.
  logic [9:0] chain_links [NUM_PAGES];
  out_item_t pending_results [$];

  typedef struct packed {
    in_item_t  req;
    logic      typed;
    out_item_t want;
  } dir_row_t;
  dir_row_t dir_rows [$];

  int sent_cnt = 0;
  int results_seen = 0;
  int fail_count = 0;
  int cycle_cnt = 0;

  always #6 clk = ~clk;

  page_chain_link_table #(.NUM_PAGES(NUM_PAGES)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  function automatic logic page_in_area(input int unsigned p);
    return p >= FIRST_PAGE && p <= LAST_PAGE;
  endfunction

  // Applies one request to the predicted table and returns its result.
  function automatic out_item_t link_table_apply(input in_item_t it);
    out_item_t res;
    int unsigned cur;
    int unsigned nxt;
    int unsigned n;
    int unsigned idle;
    logic stop;
    res = '0;
    stop = 1'b0;
    idle = 0;
    case (it.req_type)
      OP_ALLOC: begin
        res.status = STAT_FULL;
        for (n = 0; n < NUM_PAGES && !stop; n++) begin
          if (chain_links[n] == LINK_IDLE) begin
            res.status = STAT_OK;
            cur = FIRST_PAGE + n;
            res.page_out = cur[9:0];
            stop = 1'b1;
          end
        end
      end
      OP_SET: begin
        if (page_in_area(it.page)) chain_links[it.page - FIRST_PAGE] = it.link_value;
        else res.status = STAT_RANGE;
      end
      OP_FOLLOW: begin
        if (!page_in_area(it.page)) begin
          res.status = STAT_RANGE;
        end else begin
          cur = it.page;
          for (n = 0; n < it.hop_count && !stop; n++) begin
            nxt = chain_links[cur - FIRST_PAGE];
            if (nxt < FIRST_PAGE) begin
              res.status = STAT_SHORT;
              stop = 1'b1;
            end else if (!page_in_area(nxt)) begin
              res.status = STAT_RANGE;
              stop = 1'b1;
            end else begin
              cur = nxt;
            end
          end
          res.page_out = cur[9:0];
        end
      end
      OP_FREE: begin
        if (!page_in_area(it.page)) begin
          res.status = STAT_RANGE;
        end else begin
          // Clear along the chain; a cleared entry reads idle and ends the walk.
          cur = it.page;
          for (n = 0; n < NUM_PAGES && !stop; n++) begin
            nxt = chain_links[cur - FIRST_PAGE];
            chain_links[cur - FIRST_PAGE] = LINK_IDLE;
            if (nxt < FIRST_PAGE) begin
              stop = 1'b1;
            end else if (!page_in_area(nxt)) begin
              res.status = STAT_RANGE;
              stop = 1'b1;
            end else begin
              cur = nxt;
            end
          end
        end
      end
      OP_COUNT: begin
        for (n = 0; n < NUM_PAGES; n++)
          if (chain_links[n] == LINK_IDLE) idle++;
        if (idle > MAX10) idle = MAX10;
        res.idle_count = idle[9:0];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic in_item_t make_req(input logic [2:0] op, input int unsigned pg,
                                        input int unsigned lv, input int unsigned hc);
    in_item_t it;
    it.req_type = op;
    it.page = pg[9:0];
    it.link_value = lv[9:0];
    it.hop_count = hc[8:0];
    return it;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Idling phase changes every 40 items: none, sender, receiver, both.
  function automatic int sender_gap_pct();
    case ((sent_cnt / 40) % 4)
      1: return 51;
      3: return 33;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case ((sent_cnt / 40) % 4)
      2: return 51;
      3: return 33;
      default: return 0;
    endcase
  endfunction

  // Receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < receiver_stall_pct());
  end

  // Predict on every accepted item and check every accepted result in order.
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = link_table_apply(in_item);
        if (drv_typed) want = drv_want;
        pending_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending, status", out_item.status, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_item.status !== want.status)
            report_mismatch("status", out_item.status, want.status);
          if (out_item.page_out !== want.page_out)
            report_mismatch("page_out", out_item.page_out, want.page_out);
          if (out_item.idle_count !== want.idle_count)
            report_mismatch("idle_count", out_item.idle_count, want.idle_count);
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offers one item, with a random gap first, and waits until it is taken.
  task automatic send_req(input in_item_t it, input logic typed, input out_item_t want);
    int gap;
    gap = sender_gap_pct();
    while ($urandom_range(99) < gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    drv_typed <= typed;
    drv_want <= want;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic send_checked(input logic [2:0] op, input int unsigned pg,
                              input int unsigned lv, input int unsigned hc);
    send_req(make_req(op, pg, lv, hc), 1'b0, '0);
  endtask

  task automatic add_row(input logic [2:0] op, input int unsigned pg, input int unsigned lv,
                         input int unsigned hc, input logic typed, input logic [1:0] st,
                         input int unsigned po, input int unsigned ic);
    dir_row_t row;
    row.req = make_req(op, pg, lv, hc);
    row.typed = typed;
    row.want.status = st;
    row.want.page_out = po[9:0];
    row.want.idle_count = ic[9:0];
    dir_rows.push_back(row);
  endtask

  // Links every page into one long chain in shuffled order, then works on it.
  task automatic run_full_table();
    int unsigned order [NUM_PAGES];
    int unsigned k;
    int unsigned j;
    int unsigned tmp;
    logic [9:0] last_link;
    for (k = 0; k < NUM_PAGES; k++) order[k] = k + FIRST_PAGE;
    for (k = NUM_PAGES - 1; k > 0; k--) begin
      j = $urandom_range(k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    case ($urandom_range(2))
      0: last_link = LINK_TAIL;
      1: last_link = LINK_BROKEN;
      default: last_link = 10'($urandom_range(20, 2));
    endcase
    for (k = 0; k < NUM_PAGES; k++)
      send_checked(OP_SET, order[k], (k == NUM_PAGES - 1) ? last_link : order[k + 1], 0);
    send_checked(OP_ALLOC, 0, 0, 0);
    send_checked(OP_COUNT, 0, 0, 0);
    send_checked(OP_FOLLOW, order[0], 0, NUM_PAGES - 1);
    send_checked(OP_FOLLOW, order[$urandom_range(NUM_PAGES - 1)], 0, $urandom_range(511));
    // Free from a random page in the back half first so the later free stops on a cleared entry.
    send_checked(OP_FREE, order[$urandom_range(NUM_PAGES - 1, NUM_PAGES / 2)], 0, 0);
    send_checked(OP_ALLOC, 0, 0, 0);
    send_checked(OP_COUNT, 0, 0, 0);
    send_checked(OP_FREE, order[0], 0, 0);
  endtask

  // Builds a short chain with a random ending, then follows it and may free part of it.
  task automatic run_chain_burst();
    int unsigned pages [8];
    int unsigned len;
    int unsigned lo;
    int unsigned hi;
    int unsigned k;
    int unsigned ending;
    lo = FIRST_PAGE;
    hi = $urandom_range(1) ? FIRST_PAGE + 40 : LAST_PAGE;
    len = $urandom_range(8, 1);
    for (k = 0; k < len; k++) pages[k] = $urandom_range(hi, lo);
    case ($urandom_range(5))
      0: ending = LINK_TAIL;
      1: ending = LINK_BROKEN;
      2: ending = LINK_IDLE;
      3: ending = $urandom_range(20, 2);
      4: ending = $urandom_range(1023, LAST_PAGE + 1);
      default: ending = pages[0];
    endcase
    for (k = 0; k < len; k++)
      send_checked(OP_SET, pages[k], (k == len - 1) ? ending : pages[k + 1], 0);
    send_checked(OP_FOLLOW, pages[0], 0,
                 ($urandom_range(7) == 0) ? 511 : $urandom_range(len + 2));
    if ($urandom_range(3) == 0) send_checked(OP_ALLOC, 0, 0, 0);
    if ($urandom_range(1)) send_checked(OP_FREE, pages[$urandom_range(len - 1)], 0, 0);
    if ($urandom_range(5) == 0)
      send_checked(OP_FOLLOW, pages[$urandom_range(len - 1)], 0, $urandom_range(511));
  endtask

  initial begin : stimulus
    int unsigned n;
    int unsigned pick;
    int directed_cnt;
    logic [2:0] op;
    for (n = 0; n < NUM_PAGES; n++) chain_links[n] = LINK_IDLE;

    // Directed rows: empty table, boundaries of the data area, chain endings.
    add_row(OP_COUNT, 0, 0, 0, 1'b1, STAT_OK, 0, NUM_PAGES);
    add_row(OP_ALLOC, 0, 0, 0, 1'b1, STAT_OK, FIRST_PAGE, 0);
    add_row(OP_SET, FIRST_PAGE, LINK_TAIL, 0, 1'b1, STAT_OK, 0, 0);
    add_row(OP_ALLOC, 0, 0, 0, 1'b1, STAT_OK, FIRST_PAGE + 1, 0);
    add_row(OP_SET, LAST_PAGE, LINK_BROKEN, 0, 1'b1, STAT_OK, 0, 0);
    add_row(OP_SET, FIRST_PAGE - 1, 5, 0, 1'b1, STAT_RANGE, 0, 0);
    add_row(OP_SET, LAST_PAGE + 1, LINK_TAIL, 0, 1'b1, STAT_RANGE, 0, 0);
    add_row(OP_SET, 1023, 1023, 511, 1'b1, STAT_RANGE, 0, 0);
    add_row(OP_SET, 0, 0, 0, 1'b1, STAT_RANGE, 0, 0);
    add_row(OP_SET, 22, LAST_PAGE, 0, 1'b0, STAT_OK, 0, 0);
    add_row(OP_SET, 23, 22, 0, 1'b0, STAT_OK, 0, 0);
    add_row(OP_FOLLOW, 23, 0, 0, 1'b1, STAT_OK, 23, 0);
    add_row(OP_FOLLOW, 23, 0, 511, 1'b0, STAT_OK, 0, 0);
    add_row(OP_SET, 24, 1023, 0, 1'b0, STAT_OK, 0, 0);
    add_row(OP_FOLLOW, 24, 0, 3, 1'b0, STAT_OK, 0, 0);
    add_row(OP_FOLLOW, 0, 0, 1, 1'b1, STAT_RANGE, 0, 0);
    add_row(OP_FOLLOW, LAST_PAGE + 1, 0, 1, 1'b1, STAT_RANGE, 0, 0);
    add_row(OP_SET, 25, 26, 0, 1'b0, STAT_OK, 0, 0);
    add_row(OP_SET, 26, 25, 0, 1'b0, STAT_OK, 0, 0);
    add_row(OP_FOLLOW, 25, 0, 511, 1'b0, STAT_OK, 0, 0);
    add_row(OP_FREE, 25, 0, 0, 1'b0, STAT_OK, 0, 0);
    add_row(OP_FREE, 23, 0, 0, 1'b0, STAT_OK, 0, 0);
    add_row(OP_FREE, 24, 0, 0, 1'b0, STAT_OK, 0, 0);
    add_row(OP_SPARE_HI, 1023, 1023, 511, 1'b1, STAT_OK, 0, 0);
    add_row(OP_COUNT, 0, 0, 0, 1'b0, STAT_OK, 0, 0);

    // Apply reset, then release it; the block then clears its table while stalling.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    directed_cnt = sent_cnt;

    // Random part: one fully linked table, then short chains mixed with noise.
    run_full_table();
    while (sent_cnt < directed_cnt + RANDOM_ITEMS) begin
      pick = $urandom_range(9);
      if (pick <= 5) begin
        run_chain_burst();
      end else if (pick <= 7) begin
        send_checked(3'($urandom_range(OP_SPARE_HI)), $urandom_range(1023),
                     $urandom_range(1023), $urandom_range(511));
      end else if (pick == 8) begin
        send_checked($urandom_range(1) ? OP_ALLOC : OP_COUNT, 0, 0, 0);
      end else begin
        case ($urandom_range(3))
          0: op = OP_SET;
          1: op = OP_FOLLOW;
          2: op = OP_FREE;
          default: op = OP_SPARE_LO;
        endcase
        send_checked(op, $urandom_range(1) ? $urandom_range(FIRST_PAGE - 1)
                                           : $urandom_range(1023, LAST_PAGE + 1),
                     $urandom_range(1023), $urandom_range(511));
      end
    end
    in_valid <= 1'b0;

    // Wait for every result, then a little longer for anything stray.
    while (results_seen < sent_cnt) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[page_chain_link_table.f]
+incdir+rtl
rtl/pclt_pkg.sv
rtl/pclt_ram.sv
rtl/pclt_dp.sv
rtl/pclt_ctrl.sv
rtl/page_chain_link_table.sv
sim/tb_top.sv
